/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the design's checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: cond implies prop in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

// Non-overlapping implication: cond implies prop in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

/* design/smi_pkg.sv */
// ----------------------------------------------------------------------------
// smi_pkg
// Shared types, codes and helpers of the rank-one inverse update block.
// ----------------------------------------------------------------------------
package smi_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_WR_J   = 2'd0,
    OP_WR_DX  = 2'd1,
    OP_WR_DF  = 2'd2,
    OP_UPDATE = 2'd3
  } smi_op_t;

  // Update phases
  typedef enum logic [1:0] {
    PH_JDF = 2'd0,
    PH_W   = 2'd1,
    PH_D   = 2'd2,
    PH_E   = 2'd3
  } smi_phase_t;

  // Controller to datapath commands
  typedef struct packed {
    smi_phase_t phase;
    logic       load;
    logic       start;
    logic       mul_en;
    logic       acc_en;
    logic       fin;
    logic       div_ld;
    logic       div_step;
    logic       emit;
  } smi_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic keep;
    logic out_free;
  } smi_stat_t;

  // Clamp to signed 32 bits; top bit flags a clamp.
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647)
      r = {1'b1, 32'h7fff_ffff};
    else if (v < -66'sd2147483648)
      r = {1'b1, 32'h8000_0000};
    else
      r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

/* design/smi_ram.sv */
// ----------------------------------------------------------------------------
// smi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/smi_ctrl.sv */
// ----------------------------------------------------------------------------
// smi_ctrl
// Sequencer: walks the multiply-accumulate loops, divide and emit per entry.
// ----------------------------------------------------------------------------
module smi_ctrl #(
  parameter int DIM = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic [1:0]                            in_op,
  output logic                                  in_ready,
  input  smi_pkg::smi_stat_t                    stat,
  output smi_pkg::smi_cmd_t                     cmd,
  output logic [((DIM > 1) ? $clog2(DIM) : 1)-1:0] idx_i,
  output logic [((DIM > 1) ? $clog2(DIM) : 1)-1:0] idx_k
);

  localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(DIM - 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_ACC  = 8'b0000_1000,
    S_FIN  = 8'b0001_0000,
    S_DLD  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  smi_pkg::smi_phase_t phase_r, phase_nxt;
  logic [IW-1:0]       i_r, i_nxt, k_r, k_nxt;
  logic                accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_i    = i_r;
  assign idx_k    = k_r;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    i_nxt        = i_r;
    k_nxt        = k_r;
    cmd          = '0;
    cmd.phase    = phase_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = accept;
        if (accept && (smi_pkg::smi_op_t'(in_op) == smi_pkg::OP_UPDATE)) begin
          cmd.start = 1'b1;
          phase_nxt = smi_pkg::PH_JDF;
          i_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (phase_r != smi_pkg::PH_E)
          state_nxt = S_ACC;
        else if (stat.keep)
          state_nxt = S_EMIT;
        else
          state_nxt = S_DLD;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        if (k_r == LastIdx) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        k_nxt     = '0;
        state_nxt = S_RD;
        unique case (phase_r)
          smi_pkg::PH_JDF: begin
            if (i_r == LastIdx) begin
              i_nxt     = '0;
              phase_nxt = smi_pkg::PH_W;
            end else begin
              i_nxt = i_r + 1'b1;
            end
          end
          smi_pkg::PH_W: begin
            i_nxt = (i_r == LastIdx) ? '0 : i_r + 1'b1;
            if (i_r == LastIdx)
              phase_nxt = smi_pkg::PH_D;
          end
          default: begin
            i_nxt     = '0;
            phase_nxt = smi_pkg::PH_E;
          end
        endcase
      end
      S_DLD: begin
        cmd.div_ld = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done)
          state_nxt = S_EMIT;
        else
          cmd.div_step = 1'b1;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (k_r == LastIdx) begin
            k_nxt = '0;
            if (i_r == LastIdx) begin
              state_nxt = S_IDLE;
            end else begin
              i_nxt     = i_r + 1'b1;
              state_nxt = S_RD;
            end
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= smi_pkg::PH_JDF;
      i_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

/* design/smi_dp.sv */
// ----------------------------------------------------------------------------
// smi_dp
// Datapath: vector registers, shared multiplier, accumulator, serial divider,
// matrix RAM and output register.
// ----------------------------------------------------------------------------
module smi_dp #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  smi_pkg::smi_cmd_t                     cmd,
  output smi_pkg::smi_stat_t                    stat,
  input  logic [((DIM > 1) ? $clog2(DIM) : 1)-1:0] idx_i,
  input  logic [((DIM > 1) ? $clog2(DIM) : 1)-1:0] idx_k,
  input  logic [1:0]                            in_op,
  input  logic [2:0]                            in_row,
  input  logic [2:0]                            in_col,
  input  logic signed [31:0]                    in_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            out_row,
  output logic [2:0]                            out_col,
  output logic signed [31:0]                    out_value,
  output logic                                  out_last,
  output logic                                  out_unchanged,
  output logic                                  out_saturated
);

  localparam int IW   = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AW   = (DIM * DIM > 1) ? $clog2(DIM * DIM) : 1;
  localparam int AccW = 33 + $clog2(DIM);
  localparam logic [IW-1:0] LastIdx = IW'(DIM - 1);

  logic signed [31:0]   dx_r [DIM];
  logic signed [31:0]   df_r [DIM];
  logic signed [31:0]   jdf_r [DIM];
  logic signed [31:0]   u_r [DIM];
  logic signed [31:0]   w_r [DIM];
  logic signed [31:0]   d_r;
  logic signed [31:0]   jval_r;
  logic signed [63:0]   prod_r;
  logic signed [AccW-1:0] acc_r;
  logic                 sat_r;
  logic [32:0]          rem_r;
  logic [62:0]          dvd_r;
  logic [31:0]          dvs_r;
  logic                 neg_r;
  logic [5:0]           cnt_r;
  logic                 out_valid_r;
  logic [2:0]           out_row_r, out_col_r;
  logic signed [31:0]   out_value_r;
  logic                 out_last_r, out_unch_r, out_sat_r;

  logic [31:0]          ram_rd;
  logic [AW-1:0]        ram_raddr, ram_waddr;
  logic [31:0]          ram_wdata;
  logic                 ram_we;
  logic signed [31:0]   mul_a, mul_b;
  logic [32:0]          term_s, accs_s, u_s, new_s;
  logic signed [31:0]   term_v, accs_v;
  logic [32:0]          rem_sh;
  logic signed [63:0]   prod_abs;
  logic signed [63:0]   quot;
  logic                 row_ok, col_ok;
  smi_pkg::smi_op_t     op;

  assign op     = smi_pkg::smi_op_t'(in_op);
  assign row_ok = ({1'b0, in_row} < 4'(DIM));
  assign col_ok = ({1'b0, in_col} < 4'(DIM));

  // Matrix storage
  assign ram_raddr = (cmd.phase == smi_pkg::PH_W)
                   ? AW'(int'(idx_k) * DIM + int'(idx_i))
                   : AW'(int'(idx_i) * DIM + int'(idx_k));

  always_comb begin
    if (cmd.load) begin
      ram_we    = (op == smi_pkg::OP_WR_J) && row_ok && col_ok;
      ram_waddr = AW'(int'(in_row[IW-1:0]) * DIM + int'(in_col[IW-1:0]));
      ram_wdata = in_value;
    end else begin
      ram_we    = cmd.emit && !stat.keep;
      ram_waddr = AW'(int'(idx_i) * DIM + int'(idx_k));
      ram_wdata = new_s[31:0];
    end
  end

  smi_ram #(.WIDTH(32), .DEPTH(DIM * DIM)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rd)
  );

  // Multiplier operand select
  always_comb begin
    unique case (cmd.phase)
      smi_pkg::PH_JDF: begin mul_a = ram_rd;        mul_b = df_r[idx_k]; end
      smi_pkg::PH_W:   begin mul_a = dx_r[idx_k];   mul_b = ram_rd;      end
      smi_pkg::PH_D:   begin mul_a = dx_r[idx_k];   mul_b = jdf_r[idx_k]; end
      default:         begin mul_a = u_r[idx_i];    mul_b = w_r[idx_k];  end
    endcase
  end

  // Floored, clamped product and element finish
  assign term_s = smi_pkg::sat32(66'(signed'(prod_r >>> FRAC_BITS)));
  assign term_v = signed'(term_s[31:0]);
  assign accs_s = smi_pkg::sat32(66'(acc_r));
  assign accs_v = signed'(accs_s[31:0]);
  assign u_s    = smi_pkg::sat32(66'(dx_r[idx_i]) - 66'(accs_v));

  // Divider step and quotient
  assign rem_sh   = {rem_r[31:0], dvd_r[62]};
  assign prod_abs = prod_r[63] ? -prod_r : prod_r;
  assign quot     = neg_r ? -64'(signed'({1'b0, dvd_r})) : 64'(signed'({1'b0, dvd_r}));
  assign new_s    = smi_pkg::sat32(66'(jval_r) + 66'(quot));

  // Vector, accumulator and divider registers
  always_ff @(posedge clk) begin
    if (cmd.load && row_ok) begin
      if (op == smi_pkg::OP_WR_DX) dx_r[in_row[IW-1:0]] <= in_value;
      if (op == smi_pkg::OP_WR_DF) df_r[in_row[IW-1:0]] <= in_value;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
      jval_r <= signed'(ram_rd);
    end
    if (cmd.start || cmd.fin)
      acc_r <= '0;
    else if (cmd.acc_en)
      acc_r <= acc_r + AccW'(term_v);
    if (cmd.fin) begin
      unique case (cmd.phase)
        smi_pkg::PH_JDF: begin
          jdf_r[idx_i] <= accs_v;
          u_r[idx_i]   <= signed'(u_s[31:0]);
        end
        smi_pkg::PH_W: w_r[idx_i] <= accs_v;
        default:       d_r <= accs_v;
      endcase
    end
    if (cmd.div_ld) begin
      rem_r <= '0;
      dvd_r <= prod_abs[62:0];
      dvs_r <= d_r[31] ? 32'(-d_r) : 32'(d_r);
      neg_r <= prod_r[63] ^ d_r[31];
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_r <= rem_sh - {1'b0, dvs_r};
        dvd_r <= {dvd_r[61:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        dvd_r <= {dvd_r[61:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      out_row_r   <= 3'(idx_i);
      out_col_r   <= 3'(idx_k);
      out_value_r <= stat.keep ? jval_r : signed'(new_s[31:0]);
      out_last_r  <= (idx_i == LastIdx) && (idx_k == LastIdx);
      out_unch_r  <= stat.keep;
      out_sat_r   <= sat_r || (!stat.keep && new_s[32]);
    end
  end

  // Control registers: sticky clamp flag, divide count, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start)
        sat_r <= 1'b0;
      else if ((cmd.acc_en && term_s[32]) || (cmd.fin && accs_s[32])
               || (cmd.fin && cmd.phase == smi_pkg::PH_JDF && u_s[32]))
        sat_r <= 1'b1;
      if (cmd.div_ld)
        cnt_r <= 6'd63;
      else if (cmd.div_step)
        cnt_r <= cnt_r - 1'b1;
      if (cmd.emit)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  assign stat.div_done = (cnt_r == '0);
  assign stat.keep     = (d_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_last      = out_last_r;
  assign out_unchanged = out_unch_r;
  assign out_saturated = out_sat_r;

endmodule

/* design/sherman_morrison_inverse_update.sv */
// ----------------------------------------------------------------------------
// sherman_morrison_inverse_update
// Rank-one (Sherman-Morrison) update of a DIM x DIM fixed-point inverse.
// ----------------------------------------------------------------------------
// Load beats (matrix, step and change entries) are taken back to back while
// idle. An update beat holds in_tready low while one shared 32x32 multiplier
// walks the products of the 2*DIM+1 reduced elements, term by term, then of
// the DIM*DIM entries, each divided by the one-bit-per-cycle 63-step divider
// (no divide when the denominator is zero) and emitted when the result side
// is free. The matrix lives in a RAM with registered read.
module sherman_morrison_inverse_update #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[1:0], row[4:2], col[7:5], value[39:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6], 0
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // unchanged[0], saturated[1]
);

  localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;

  smi_pkg::smi_cmd_t  cmd;
  smi_pkg::smi_stat_t stat;
  logic [IW-1:0]      idx_i, idx_k;
  logic [2:0]         o_row, o_col;
  logic signed [31:0] o_value;
  logic               o_unch, o_sat;

  smi_ctrl #(.DIM(DIM)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tdata[1:0]),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd),
    .idx_i    (idx_i),
    .idx_k    (idx_k)
  );

  smi_dp #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .idx_i         (idx_i),
    .idx_k         (idx_k),
    .in_op         (in_tdata[1:0]),
    .in_row        (in_tdata[4:2]),
    .in_col        (in_tdata[7:5]),
    .in_value      (signed'(in_tdata[39:8])),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_row       (o_row),
    .out_col       (o_col),
    .out_value     (o_value),
    .out_last      (out_tlast),
    .out_unchanged (o_unch),
    .out_saturated (o_sat)
  );

  assign out_tdata = {2'b00, o_value, o_col, o_row};
  assign out_tuser = {o_sat, o_unch};

endmodule

/* design/smi_checker.sv */
// ----------------------------------------------------------------------------
// smi_checker
// Port-level checks of the update block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  logic upd_beat;

  // Accepted update beat
  assign upd_beat = in_tvalid && in_tready
                    && (smi_pkg::smi_op_t'(in_tdata[1:0]) == smi_pkg::OP_UPDATE);

  // A stalled result beat stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  // An update beat blocks input on the next cycle
  `ASSERT_NEXT(a_upd_busy, clk, rst_n, upd_beat, !in_tready)
  // Input stays blocked between the beats of one emitted matrix
  `ASSERT_IMPL(a_mid_busy, clk, rst_n, out_tvalid && out_tready && !out_tlast, !in_tready)
  // Padding bits of the result stay zero
  `ASSERT_IMPL(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[39:38] == 2'b00)

endmodule

bind sherman_morrison_inverse_update smi_checker u_smi_checker (.*);

/* tb/sherman_morrison_inverse_update_tb.sv */
// ----------------------------------------------------------------------------
// sherman_morrison_inverse_update_tb
// Self-checking bench for the rank-one inverse update: loads matrix, step and
// change entries, issues updates, and compares every emitted entry against a
// fixed-point predictor kept in the bench, under several idling phases.
// ----------------------------------------------------------------------------
module sherman_morrison_inverse_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM  = 4;
  localparam int FRAC = 16;

  typedef struct packed {
    logic [2:0]  r;
    logic [2:0]  c;
    logic [31:0] v;
    logic        lst;
    logic        unch;
    logic        sat;
  } entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  sherman_morrison_inverse_update #(.DIM(DIM), .FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always #4 clk = ~clk;

  // predictor state
  longint jmat [DIM*DIM];
  longint step_v [DIM];
  longint chg_v [DIM];
  bit     sat_any;

  logic [39:0] pending_beats[$];
  entry_t      expected_entries[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_send = 1'b0;

  function automatic longint clamp(longint v, ref bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = (a * b) >>> FRAC;  // arithmetic shift floors
    return clamp(p, sat_any);
  endfunction

  // apply one input beat to the predictor, pushing any emitted entries
  function automatic void predict_beat(logic [39:0] beat);
    smi_pkg::smi_op_t op;
    int      row, col, i, j, k;
    longint  val, acc, d, v, q;
    longint  jdf[DIM], u[DIM], w[DIM];
    bit      keep, esat;
    entry_t  e;
    op  = smi_pkg::smi_op_t'(beat[1:0]);
    row = int'(beat[4:2]);
    col = int'(beat[7:5]);
    val = longint'($signed(beat[39:8]));
    unique case (op)
      smi_pkg::OP_WR_J: begin
        if (row < DIM && col < DIM) jmat[row*DIM+col] = val;
      end
      smi_pkg::OP_WR_DX: begin
        if (row < DIM) step_v[row] = val;
      end
      smi_pkg::OP_WR_DF: begin
        if (row < DIM) chg_v[row] = val;
      end
      default: begin
        sat_any = 1'b0;
        for (i = 0; i < DIM; i++) begin
          acc = 0;
          for (k = 0; k < DIM; k++) acc += fx_mul(jmat[i*DIM+k], chg_v[k]);
          jdf[i] = clamp(acc, sat_any);
          u[i] = clamp(step_v[i] - jdf[i], sat_any);
        end
        for (j = 0; j < DIM; j++) begin
          acc = 0;
          for (k = 0; k < DIM; k++) acc += fx_mul(step_v[k], jmat[k*DIM+j]);
          w[j] = clamp(acc, sat_any);
        end
        acc = 0;
        for (i = 0; i < DIM; i++) acc += fx_mul(step_v[i], jdf[i]);
        d = clamp(acc, sat_any);
        keep = (d == 0);
        for (i = 0; i < DIM; i++) begin
          for (j = 0; j < DIM; j++) begin
            esat = 1'b0;
            v = jmat[i*DIM+j];
            if (!keep) begin
              q = (u[i] * w[j]) / d;  // truncates toward zero
              v = clamp(v + q, esat);
              jmat[i*DIM+j] = v;
            end
            e.r = 3'(i); e.c = 3'(j); e.v = v[31:0];
            e.lst = (i == DIM-1 && j == DIM-1);
            e.unch = keep;
            e.sat = sat_any | esat;
            expected_entries.push_back(e);
          end
        end
      end
    endcase
  endfunction

  function automatic logic [39:0] mk(smi_pkg::smi_op_t op, int r, int c, logic [31:0] v);
    return {v, 3'(c), 3'(r), op};
  endfunction

  // random Q16.16 value: mostly moderate, sometimes full range
  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h0001_0000;
      2: return 32'h0;
      default: return 32'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  // load a full, well-conditioned set then update
  task automatic queue_full_set();
    int i, j;
    for (i = 0; i < DIM; i++)
      for (j = 0; j < DIM; j++)
        pending_beats.push_back(mk(smi_pkg::OP_WR_J, i, j,
          (i == j) ? 32'h0001_0000 + ($urandom_range(0, 65535)) : rnd_val()));
    for (i = 0; i < DIM; i++) begin
      pending_beats.push_back(mk(smi_pkg::OP_WR_DX, i, $urandom_range(0, 7), rnd_val()));
      pending_beats.push_back(mk(smi_pkg::OP_WR_DF, i, $urandom_range(0, 7), rnd_val()));
    end
    pending_beats.push_back(mk(smi_pkg::OP_UPDATE, $urandom_range(0, 7),
                               $urandom_range(0, 7), $urandom()));
  endtask

  // reload step and change vectors only, then update
  task automatic queue_vec_set();
    int i;
    for (i = 0; i < DIM; i++) begin
      pending_beats.push_back(mk(smi_pkg::OP_WR_DX, i, 0, rnd_val()));
      pending_beats.push_back(mk(smi_pkg::OP_WR_DF, i, 0, rnd_val()));
    end
    pending_beats.push_back(mk(smi_pkg::OP_UPDATE, 0, 0, $urandom()));
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_tready) begin
      // hold beat
    end else begin
      if (in_tvalid) begin
        predict_beat(in_tdata);
        void'(pending_beats.pop_front());
      end
      if (pending_beats.size() > (in_tvalid ? 1 : 0) - (in_tvalid ? 1 : 0) &&
          pending_beats.size() != 0 && !hold_send &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_beats[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk)
    out_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);

  // monitor
  always @(posedge clk) begin
    entry_t got, exp_e;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[2:0], out_tdata[5:3], out_tdata[37:6], out_tlast,
             out_tuser[0], out_tuser[1]};
      if (expected_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        exp_e = expected_entries.pop_front();
        if (got !== exp_e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp r%0d c%0d v%h l%b u%b s%b, got r%0d c%0d v%h l%b u%b s%b",
              exp_e.r, exp_e.c, exp_e.v, exp_e.lst, exp_e.unch, exp_e.sat,
              got.r, got.c, got.v, got.lst, got.unch, got.sat);
        end
      end
    end
  end

  task automatic drain();
    while (pending_beats.size() != 0 || in_tvalid || expected_entries.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int i, j, ph;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: identity J, extremes, out-of-range loads, zero denominator
    for (i = 0; i < DIM; i++)
      for (j = 0; j < DIM; j++)
        pending_beats.push_back(mk(smi_pkg::OP_WR_J, i, j,
                                   (i == j) ? 32'h0001_0000 : 32'h0));
    for (i = 0; i < DIM; i++) begin
      pending_beats.push_back(mk(smi_pkg::OP_WR_DX, i, 7, 32'h0));
      pending_beats.push_back(mk(smi_pkg::OP_WR_DF, i, 0, 32'h0001_0000));
    end
    pending_beats.push_back(mk(smi_pkg::OP_WR_J, 7, 0, 32'hffff_ffff));
    pending_beats.push_back(mk(smi_pkg::OP_WR_J, 0, 7, 32'h8000_0000));
    pending_beats.push_back(mk(smi_pkg::OP_WR_DX, 5, 0, 32'h7fff_ffff));
    pending_beats.push_back(mk(smi_pkg::OP_WR_DF, 6, 0, 32'h8000_0000));
    pending_beats.push_back(mk(smi_pkg::OP_UPDATE, 0, 0, 32'h0));  // zero denominator
    pending_beats.push_back(mk(smi_pkg::OP_WR_DX, 0, 0, 32'h7fff_ffff));
    pending_beats.push_back(mk(smi_pkg::OP_WR_DX, 1, 0, 32'h8000_0000));
    pending_beats.push_back(mk(smi_pkg::OP_WR_DF, 0, 0, 32'h7fff_ffff));
    pending_beats.push_back(mk(smi_pkg::OP_UPDATE, 7, 7, 32'hffff_ffff));  // saturating
    drain();

    // pause until idle, then one more directed update
    hold_send = 1'b1;
    repeat (20) @(posedge clk);
    hold_send = 1'b0;
    pending_beats.push_back(mk(smi_pkg::OP_WR_DX, 2, 0, 32'h0000_8000));
    pending_beats.push_back(mk(smi_pkg::OP_UPDATE, 3, 3, 32'h0));
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 88 : (ph == 3) ? 26 : 0;
      recv_stall_pct = (ph == 2) ? 88 : (ph == 3) ? 26 : 0;
      if (ph == 0 || ph == 2) queue_full_set();
      else queue_vec_set();
      if (ph != 2) begin
        for (i = 0; i < 4; i++) begin
          case ($urandom_range(0, 3))
            0: pending_beats.push_back(mk(smi_pkg::OP_WR_J, $urandom_range(0, 7),
                                          $urandom_range(0, 7), rnd_val()));
            1: pending_beats.push_back(mk(smi_pkg::OP_WR_DX, $urandom_range(0, 7),
                                          0, rnd_val()));
            2: pending_beats.push_back(mk(smi_pkg::OP_WR_DF, $urandom_range(0, 7),
                                          0, rnd_val()));
            default: pending_beats.push_back(mk(smi_pkg::OP_UPDATE, $urandom_range(0, 7),
                                                $urandom_range(0, 7), $urandom()));
          endcase
        end
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_entries.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/smi_pkg.sv
design/smi_ram.sv
design/smi_ctrl.sv
design/smi_dp.sv
design/sherman_morrison_inverse_update.sv
design/smi_checker.sv
tb/sherman_morrison_inverse_update_tb.sv
